// ----- sv/dap_pkg.sv -----
// Shared types and constants for the DNS answer parser.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package dap_pkg;

    // Phase of the walk through the datagram, one-hot coded.
    typedef enum logic [6:0] {
        PH_HEADER = 7'b000_0001,
        PH_QNAME  = 7'b000_0010,
        PH_QFIXED = 7'b000_0100,
        PH_ANAME  = 7'b000_1000,
        PH_AFIXED = 7'b001_0000,
        PH_RDATA  = 7'b010_0000,
        PH_IGNORE = 7'b100_0000
    } t_phase;

    // Record kind codes; KIND_BAD is internal and never leaves the block.
    localparam logic [1:0] KIND_IPV4 = 2'd0;
    localparam logic [1:0] KIND_IPV6 = 2'd1;
    localparam logic [1:0] KIND_NAME = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    localparam logic [7:0] TYPE_A     = 8'd1;
    localparam logic [7:0] TYPE_AAAA  = 8'd28;
    localparam logic [7:0] TYPE_PTR   = 8'd12;
    localparam logic [7:0] LABEL_MAX  = 8'd63;
    localparam logic [7:0] ASCII_DOT  = 8'h2E;

    // Byte positions inside the fixed parts.
    localparam logic [3:0] HDR_ANCOUNT_HI = 4'd6;
    localparam logic [3:0] HDR_ANCOUNT_LO = 4'd7;
    localparam logic [3:0] HDR_LAST       = 4'd11;
    localparam logic [3:0] QFIX_LAST      = 4'd3;
    localparam logic [3:0] AFIX_TYPE_HI   = 4'd0;
    localparam logic [3:0] AFIX_TYPE_LO   = 4'd1;
    localparam logic [3:0] AFIX_RDLEN_HI  = 4'd8;
    localparam logic [3:0] AFIX_RDLEN_LO  = 4'd9;

    typedef struct packed {
        logic [15:0] record_index;
        logic [1:0]  record_kind;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        record_done;
        logic        bad_type;
    } t_result;

endpackage

// ----- sv/dap_parser.sv -----
// Parser state and the per-byte update logic of the DNS answer parser.
// Depends on dap_pkg for the phase type, constants and result struct.
`timescale 1ns / 1ps

module dap_parser
    import dap_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output logic       o_emit,
    output t_result    o_result
);

    t_phase      r_phase,   n_phase;
    logic [3:0]  r_sc,      n_sc;
    logic [15:0] r_total,   n_total;
    logic [15:0] r_done,    n_done;
    logic [15:0] r_rdata,   n_rdata;
    logic [1:0]  r_kind,    n_kind;
    logic [5:0]  r_label,   n_label;
    logic        r_ptr,     n_ptr;
    logic        r_first,   n_first;
    logic        r_ended,   n_ended;

    // Name skipping shared by the question and answer owner names.
    logic        w_skip_end;
    logic [5:0]  w_skip_label;
    logic        w_skip_ptr;
    logic        w_is_ptr;
    logic [15:0] w_done_inc;
    logic [15:0] w_rdata_dec;

    assign w_is_ptr    = (i_byte > LABEL_MAX);
    assign w_done_inc  = r_done + 16'd1;
    assign w_rdata_dec = r_rdata - 16'd1;

    always_comb begin
        w_skip_end   = 1'b0;
        w_skip_label = r_label;
        w_skip_ptr   = r_ptr;
        if (r_ptr) begin
            w_skip_ptr = 1'b0;
            w_skip_end = 1'b1;
        end else if (r_label != 6'd0) begin
            w_skip_label = r_label - 6'd1;
        end else if (i_byte == 8'd0) begin
            w_skip_end = 1'b1;
        end else if (w_is_ptr) begin
            w_skip_ptr = 1'b1;
        end else begin
            w_skip_label = i_byte[5:0];
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_sc    = r_sc;
        n_total = r_total;
        n_done  = r_done;
        n_rdata = r_rdata;
        n_kind  = r_kind;
        n_label = r_label;
        n_ptr   = r_ptr;
        n_first = r_first;
        n_ended = r_ended;
        o_emit  = 1'b0;
        o_result = '0;
        o_result.record_index = r_done;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_sc == HDR_ANCOUNT_HI) begin
                    n_total[15:8] = i_byte;
                end else if (r_sc == HDR_ANCOUNT_LO) begin
                    n_total[7:0] = i_byte;
                end
                if (r_sc >= HDR_LAST) begin
                    n_sc    = '0;
                    n_label = '0;
                    n_ptr   = 1'b0;
                    n_first = 1'b1;
                    n_ended = 1'b0;
                    n_phase = PH_QNAME;
                end else begin
                    n_sc = r_sc + 4'd1;
                end
            end
            PH_QNAME, PH_ANAME: begin
                n_label = w_skip_label;
                n_ptr   = w_skip_ptr;
                if (w_skip_end) begin
                    n_sc    = '0;
                    n_phase = (r_phase == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                end
            end
            PH_QFIXED: begin
                if (r_sc >= QFIX_LAST) begin
                    n_sc    = '0;
                    n_label = '0;
                    n_ptr   = 1'b0;
                    n_first = 1'b1;
                    n_ended = 1'b0;
                    n_phase = (r_total == 16'd0) ? PH_IGNORE : PH_ANAME;
                end else begin
                    n_sc = r_sc + 4'd1;
                end
            end
            PH_AFIXED: begin
                if (r_sc == AFIX_TYPE_HI) begin
                    n_kind = (i_byte != 8'd0) ? KIND_BAD : KIND_IPV4;
                end else if (r_sc == AFIX_TYPE_LO && r_kind != KIND_BAD) begin
                    if (i_byte == TYPE_A) begin
                        n_kind = KIND_IPV4;
                    end else if (i_byte == TYPE_AAAA) begin
                        n_kind = KIND_IPV6;
                    end else if (i_byte == TYPE_PTR) begin
                        n_kind = KIND_NAME;
                    end else begin
                        n_kind = KIND_BAD;
                    end
                end else if (r_sc == AFIX_RDLEN_HI) begin
                    n_rdata[15:8] = i_byte;
                end else if (r_sc == AFIX_RDLEN_LO) begin
                    n_rdata[7:0] = i_byte;
                end
                if (r_sc >= AFIX_RDLEN_LO) begin
                    n_sc = '0;
                    if (r_kind == KIND_BAD) begin
                        o_emit            = 1'b1;
                        o_result.bad_type = 1'b1;
                        n_phase           = PH_IGNORE;
                    end else if (n_rdata == 16'd0) begin
                        // Empty record data still closes the record.
                        o_emit               = 1'b1;
                        o_result.record_done = 1'b1;
                        o_result.record_kind = r_kind;
                        n_done  = w_done_inc;
                        n_label = '0;
                        n_ptr   = 1'b0;
                        n_first = 1'b1;
                        n_ended = 1'b0;
                        n_phase = (w_done_inc >= r_total) ? PH_IGNORE : PH_ANAME;
                    end else begin
                        n_label = '0;
                        n_ptr   = 1'b0;
                        n_first = 1'b1;
                        n_ended = 1'b0;
                        n_phase = PH_RDATA;
                    end
                end else begin
                    n_sc = r_sc + 4'd1;
                end
            end
            PH_RDATA: begin
                o_result.record_kind = r_kind;
                if (r_kind == KIND_NAME) begin
                    // Label lengths turn into dots; pointers are stepped over.
                    if (r_ended) begin
                        // Bytes after the terminating zero give no text.
                    end else if (r_ptr) begin
                        n_ptr = 1'b0;
                    end else if (r_label != 6'd0) begin
                        n_label = r_label - 6'd1;
                        o_result.data_valid = 1'b1;
                        o_result.data_byte  = i_byte;
                    end else if (i_byte == 8'd0) begin
                        n_ended = 1'b1;
                    end else if (w_is_ptr) begin
                        n_ptr = 1'b1;
                    end else begin
                        n_label = i_byte[5:0];
                        if (!r_first) begin
                            o_result.data_valid = 1'b1;
                            o_result.data_byte  = ASCII_DOT;
                        end else begin
                            n_first = 1'b0;
                        end
                    end
                end else begin
                    o_result.data_valid = 1'b1;
                    o_result.data_byte  = i_byte;
                end
                n_rdata = w_rdata_dec;
                if (w_rdata_dec == 16'd0) begin
                    o_result.record_done = 1'b1;
                    n_done  = w_done_inc;
                    n_label = '0;
                    n_ptr   = 1'b0;
                    n_first = 1'b1;
                    n_ended = 1'b0;
                    n_phase = (w_done_inc >= r_total) ? PH_IGNORE : PH_ANAME;
                end
                o_emit = o_result.data_valid || o_result.record_done;
            end
            PH_IGNORE: begin
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        // The last byte of a datagram returns everything to reset.
        if (i_end) begin
            n_phase = PH_HEADER;
            n_sc    = '0;
            n_total = '0;
            n_done  = '0;
            n_rdata = '0;
            n_kind  = KIND_IPV4;
            n_label = '0;
            n_ptr   = 1'b0;
            n_first = 1'b1;
            n_ended = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_sc    <= '0;
            r_total <= '0;
            r_done  <= '0;
            r_rdata <= '0;
            r_kind  <= KIND_IPV4;
            r_label <= '0;
            r_ptr   <= 1'b0;
            r_first <= 1'b1;
            r_ended <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_sc    <= n_sc;
            r_total <= n_total;
            r_done  <= n_done;
            r_rdata <= n_rdata;
            r_kind  <= n_kind;
            r_label <= n_label;
            r_ptr   <= n_ptr;
            r_first <= n_first;
            r_ended <= n_ended;
        end
    end

endmodule

// ----- sv/dap_out_reg.sv -----
// Result register of the DNS answer parser, holding one result for the receiver.
// Depends on dap_pkg for the result struct.
`timescale 1ns / 1ps

module dap_out_reg
    import dap_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_out_ready,
    output logic    o_free,
    output logic    o_out_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // The slot can take a new result when empty or being emptied this cycle.
    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- sv/dns_answer_parser_unit.sv -----
// Top level of the DNS answer parser: input register, parser and result register.
// Depends on dap_pkg, dap_parser and dap_out_reg.
`timescale 1ns / 1ps

// The block takes a DNS response datagram one byte per request on the input
// channel (i_in_valid / o_in_ready, with i_packet_end set on the final byte)
// and returns address bytes, PTR name characters, record ends and unknown-type
// errors as result requests on the output channel (o_out_valid / i_out_ready).
// Bytes that produce nothing, such as header and owner name bytes, give no
// result request at all.
// An accepted byte sits in the input register while the parser state is
// updated, and its result, if any, is loaded into the result register when
// the byte steps the parser, and is offered from there. One byte is taken
// in every cycle as long as results are taken; the only loop is the parser
// state update.
// When the receiver stalls, the result register holds its result and the
// input register keeps taking bytes that produce no result; a byte that
// would produce a result waits in the input register, and o_in_ready drops
// only then. A byte with i_packet_end set is handled normally and then
// returns the parser to its header phase for the next datagram.
// Synchronous reset (i_rst_n low) empties both registers and puts the parser
// in its header phase with counts cleared.
module dns_answer_parser_unit
    import dap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_packet_byte,
    input  logic        i_packet_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_record_index,
    output logic [1:0]  o_record_kind,
    output logic        o_data_valid,
    output logic [7:0]  o_data_byte,
    output logic        o_record_done,
    output logic        o_bad_type
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    logic       w_emit;
    logic       w_free;
    logic       w_step;
    t_result    w_step_result;
    t_result    w_out_result;

    // The held byte moves on when it gives no result or the result slot is free.
    assign w_step     = r_in_valid && (!w_emit || w_free);
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_packet_byte;
            r_in_end  <= i_packet_end;
        end
    end

    dap_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .i_end    (r_in_end),
        .o_emit   (w_emit),
        .o_result (w_step_result)
    );

    dap_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_step && w_emit),
        .i_result    (w_step_result),
        .i_out_ready (i_out_ready),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .o_result    (w_out_result)
    );

    assign o_record_index = w_out_result.record_index;
    assign o_record_kind  = w_out_result.record_kind;
    assign o_data_valid   = w_out_result.data_valid;
    assign o_data_byte    = w_out_result.data_byte;
    assign o_record_done  = w_out_result.record_done;
    assign o_bad_type     = w_out_result.bad_type;

endmodule
